// ===== hw/rtl/bq_pkg.sv =====
// shared types and constants for the biquad cascade filter
package bq_pkg;

    localparam int BQ_MAX_STAGES = 8;
    localparam int BQ_STG_W      = (BQ_MAX_STAGES > 1) ? $clog2(BQ_MAX_STAGES) : 1;

    localparam logic BQ_ACT_FILTER = 1'b0;
    localparam logic BQ_ACT_COEF   = 1'b1;

    localparam logic [2:0] BQ_SLOT_B0 = 3'd0;
    localparam logic [2:0] BQ_SLOT_B1 = 3'd1;
    localparam logic [2:0] BQ_SLOT_B2 = 3'd2;
    localparam logic [2:0] BQ_SLOT_A1 = 3'd3;
    localparam logic [2:0] BQ_SLOT_A2 = 3'd4;

    // sample handed from one cell to the next
    typedef struct packed {
        logic               vld;
        logic signed [15:0] x;
    } t_bq_link;

    // coefficient write aimed at one cell
    typedef struct packed {
        logic               we;
        logic        [2:0]  slot;
        logic signed [17:0] value;
    } t_bq_cwr;

    // per-cell status back to the top level
    typedef struct packed {
        logic               done;
        logic               sat;
        logic signed [15:0] y;
    } t_bq_stat;

endpackage

// ===== hw/rtl/biquad_cascade_filter.sv =====
// top level of the cascaded biquad filter: control, cell chain and result buffer
// Cascade of up to BQ_MAX_STAGES (8) transposed direct form II biquad sections
// built as a row of cells, one cell per section, each holding its own five
// Q2.16 coefficients and two saturating 32-bit delay words. A sample beat
// (action 0) is registered at the head of the row and enters cell 0 on the
// next cycle. Each cell registers the sample through r_a_vld and r_b_vld
// before handing its Q1.15 output to the next cell. The last active cell
// finishes its delay update one register further on, at r_c_vld, and its
// result lands in the output register on that same edge. The block holds one
// sample at a time and takes no new sample until the previous one is done.
// A coefficient beat (action 1) does not occupy the row and gives no result;
// slots 5..7 and stages past the last cell are ignored. active_stages is
// written through i_cfg_we/i_cfg_wdata; the user must write it only while the
// block is idle, as the block itself does not enforce this. 0 acts as 1 and
// values past the cell count act as the full cascade. Results sit in an
// output register backed by one spare entry, so the next beat is taken
// while a result still waits downstream.
module biquad_cascade_filter
    import bq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic        [3:0]  i_cfg_wdata,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_action,
    input  logic signed [15:0] i_sample_in,
    input  logic               i_block_end,
    input  logic        [2:0]  i_coef_stage,
    input  logic        [2:0]  i_coef_slot,
    input  logic signed [17:0] i_coef_value,
    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_sample_out,
    output logic               o_saturated,
    output logic               o_block_end_out
);

    // config and control
    logic [3:0]          r_active_stages;
    logic [BQ_STG_W-1:0] r_last_idx;
    logic [BQ_STG_W-1:0] n_last_idx;
    logic                r_busy;
    logic                r_flag;
    logic                r_blk_end;
    t_bq_link            r_head;

    // result buffer: output register plus one spare entry
    logic               r_out_vld;
    logic signed [15:0] r_out_y;
    logic               r_out_sat;
    logic               r_out_blk;
    logic               r_pend_vld;
    logic signed [15:0] r_pend_y;
    logic               r_pend_sat;
    logic               r_pend_blk;

    logic w_acc_in;
    logic w_smp_acc;
    logic w_coef_acc;
    logic w_take;

    // cell row wiring
    t_bq_link w_lin  [BQ_MAX_STAGES];
    t_bq_link w_lout [BQ_MAX_STAGES];
    t_bq_cwr  w_cwr  [BQ_MAX_STAGES];
    t_bq_stat w_stat [BQ_MAX_STAGES];
    logic     [BQ_MAX_STAGES-1:0] w_last;
    logic     [BQ_MAX_STAGES-1:0] w_done_vec;

    logic               w_done;
    logic               w_sat_any;
    logic signed [15:0] w_res_y;
    logic               w_res_sat;

    assign o_stall    = r_busy | r_pend_vld;
    assign w_acc_in   = i_valid & ~o_stall;
    assign w_smp_acc  = w_acc_in & (i_action == BQ_ACT_FILTER);
    assign w_coef_acc = w_acc_in & (i_action == BQ_ACT_COEF);
    assign w_take     = r_out_vld & ~i_stall;

    // index of the last stage run, stage count clamped to the cell row
    always_comb begin
        if (r_active_stages == 4'd0) begin
            n_last_idx = '0;
        end else if (32'(r_active_stages) > BQ_MAX_STAGES) begin
            n_last_idx = BQ_STG_W'(BQ_MAX_STAGES - 1);
        end else begin
            n_last_idx = BQ_STG_W'(r_active_stages - 4'd1);
        end
    end

    // the cell row
    for (genvar k = 0; k < BQ_MAX_STAGES; k++) begin : g_cell
        if (k == 0) begin : g_first
            assign w_lin[k] = r_head;
        end else begin : g_rest
            assign w_lin[k] = w_lout[k-1];
        end
        assign w_last[k]     = (32'(r_last_idx) == k);
        assign w_cwr[k].we   = w_coef_acc & (32'(i_coef_stage) == k);
        assign w_cwr[k].slot = i_coef_slot;
        assign w_cwr[k].value = i_coef_value;
        assign w_done_vec[k] = w_stat[k].done;

        bq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_link  (w_lin[k]),
            .i_last  (w_last[k]),
            .i_cwr   (w_cwr[k]),
            .o_link  (w_lout[k]),
            .o_stat  (w_stat[k])
        );
    end

    // only the last active cell raises done, so an or across the row picks it
    always_comb begin
        w_done    = 1'b0;
        w_sat_any = 1'b0;
        w_res_y   = '0;
        for (int k = 0; k < BQ_MAX_STAGES; k++) begin
            w_done    = w_done | w_stat[k].done;
            w_sat_any = w_sat_any | w_stat[k].sat;
            if (w_stat[k].done) begin
                w_res_y = w_res_y | w_stat[k].y;
            end
        end
    end

    // saturation of any stage of this sample, including the final update
    assign w_res_sat = r_flag | w_sat_any;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_stages <= 4'd1;
            r_last_idx      <= '0;
            r_busy          <= 1'b0;
            r_flag          <= 1'b0;
            r_head.vld      <= 1'b0;
            r_out_vld       <= 1'b0;
            r_pend_vld      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active_stages <= i_cfg_wdata;
            end
            r_head.vld <= w_smp_acc;
            if (w_smp_acc) begin
                r_head.x   <= i_sample_in;
                r_last_idx <= n_last_idx;
                r_busy     <= 1'b1;
                r_flag     <= 1'b0;
            end else begin
                if (w_done) begin
                    r_busy <= 1'b0;
                end
                if (w_sat_any) begin
                    r_flag <= 1'b1;
                end
            end
            // result lands in the output register, or in the spare when blocked
            if (w_done) begin
                if (!r_out_vld || w_take) begin
                    r_out_vld <= 1'b1;
                end else begin
                    r_pend_vld <= 1'b1;
                end
            end else if (w_take) begin
                r_out_vld  <= r_pend_vld;
                r_pend_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_smp_acc) begin
            r_blk_end <= i_block_end;
        end
        if (w_done) begin
            if (!r_out_vld || w_take) begin
                r_out_y   <= w_res_y;
                r_out_sat <= w_res_sat;
                r_out_blk <= r_blk_end;
            end else begin
                r_pend_y   <= w_res_y;
                r_pend_sat <= w_res_sat;
                r_pend_blk <= r_blk_end;
            end
        end else if (w_take && r_pend_vld) begin
            r_out_y   <= r_pend_y;
            r_out_sat <= r_pend_sat;
            r_out_blk <= r_pend_blk;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_sample_out    = r_out_y;
    assign o_saturated     = r_out_sat;
    assign o_block_end_out = r_out_blk;

    // a finished sample only comes out of a busy row, from a single cell
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_busy)
        else $error("cell row finished a sample while idle");

    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_done_vec))
        else $error("more than one cell finished in the same cycle");

    // the final cell never hands a sample past the end of the row
    a_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_lout[BQ_MAX_STAGES-1].vld)
        else $error("sample forwarded past the last cell");

    // the spare entry fills only behind a held output register
    a_pend_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> r_out_vld)
        else $error("spare result entry valid with empty output register");

endmodule

// ===== hw/rtl/bq_cell.sv =====
// one biquad section: coefficients, two delay words and a four-step datapath
module bq_cell
    import bq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_bq_link i_link,
    input  logic     i_last,
    input  t_bq_cwr  i_cwr,
    output t_bq_link o_link,
    output t_bq_stat o_stat
);

    // product rounded to the state format, half toward plus infinity
    function automatic logic signed [32:0] rnd1(input logic signed [33:0] p);
        logic signed [33:0] t;
        t = p + 34'sd1;
        return $signed(t[33:1]);
    endfunction

    logic signed [17:0] r_b0, r_b1, r_b2, r_a1, r_a2;
    logic signed [31:0] r_d0, r_d1;

    logic               r_a_vld, r_b_vld, r_c_vld, r_last;
    logic signed [33:0] r_p0, r_p1, r_p2, r_q3, r_q4;
    logic signed [32:0] r_r1, r_r2;
    logic signed [15:0] r_y;
    logic               r_sat_y;

    logic signed [15:0] w_x;
    logic signed [33:0] w_m0, w_m1, w_m2, w_m3, w_m4;
    logic signed [35:0] w_acc, w_acc_r;
    logic signed [20:0] w_yf;
    logic signed [15:0] w_y;
    logic               w_sat_y;
    logic signed [35:0] w_n0, w_n1;
    logic signed [31:0] w_d0, w_d1;
    logic               w_sat0, w_sat1;

    assign w_x  = i_link.x;
    assign w_m0 = 34'(r_b0) * 34'(w_x);
    assign w_m1 = 34'(r_b1) * 34'(w_x);
    assign w_m2 = 34'(r_b2) * 34'(w_x);
    assign w_m3 = 34'(r_a1) * 34'(r_y);
    assign w_m4 = 34'(r_a2) * 34'(r_y);

    // stage output: acc rounded by 2^15, saturated to 16 bits
    always_comb begin
        w_acc   = 36'(rnd1(r_p0)) + 36'(r_d0);
        w_acc_r = w_acc + 36'sd16384;
        w_yf    = $signed(w_acc_r[35:15]);
        w_sat_y = 1'b0;
        if (w_yf > 21'sd32767) begin
            w_y     = 16'sh7FFF;
            w_sat_y = 1'b1;
        end else if (w_yf < -21'sd32768) begin
            w_y     = 16'sh8000;
            w_sat_y = 1'b1;
        end else begin
            w_y = w_yf[15:0];
        end
    end

    // delay word updates with 32-bit saturation
    always_comb begin
        w_n0   = 36'(r_r1) - 36'(rnd1(r_q3)) + 36'(r_d1);
        w_n1   = 36'(r_r2) - 36'(rnd1(r_q4));
        w_sat0 = 1'b0;
        w_sat1 = 1'b0;
        if (w_n0 > 36'sh07FFFFFFF) begin
            w_d0   = 32'sh7FFFFFFF;
            w_sat0 = 1'b1;
        end else if (w_n0 < -36'sh080000000) begin
            w_d0   = 32'sh80000000;
            w_sat0 = 1'b1;
        end else begin
            w_d0 = w_n0[31:0];
        end
        if (w_n1 > 36'sh07FFFFFFF) begin
            w_d1   = 32'sh7FFFFFFF;
            w_sat1 = 1'b1;
        end else if (w_n1 < -36'sh080000000) begin
            w_d1   = 32'sh80000000;
            w_sat1 = 1'b1;
        end else begin
            w_d1 = w_n1[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0    <= '0;
            r_b1    <= '0;
            r_b2    <= '0;
            r_a1    <= '0;
            r_a2    <= '0;
            r_d0    <= '0;
            r_d1    <= '0;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_a_vld <= i_link.vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            if (i_cwr.we) begin
                case (i_cwr.slot)
                    BQ_SLOT_B0: r_b0 <= i_cwr.value;
                    BQ_SLOT_B1: r_b1 <= i_cwr.value;
                    BQ_SLOT_B2: r_b2 <= i_cwr.value;
                    BQ_SLOT_A1: r_a1 <= i_cwr.value;
                    BQ_SLOT_A2: r_a2 <= i_cwr.value;
                    default: ;
                endcase
            end
            if (i_link.vld) begin
                r_last <= i_last;
            end
            if (r_c_vld) begin
                r_d0 <= w_d0;
                r_d1 <= w_d1;
            end
        end
    end

    // payload path, loaded only on the valid step
    always_ff @(posedge i_clk) begin
        if (i_link.vld) begin
            r_p0 <= w_m0;
            r_p1 <= w_m1;
            r_p2 <= w_m2;
        end
        if (r_a_vld) begin
            r_y     <= w_y;
            r_sat_y <= w_sat_y;
            r_r1    <= rnd1(r_p1);
            r_r2    <= rnd1(r_p2);
        end
        if (r_b_vld) begin
            r_q3 <= w_m3;
            r_q4 <= w_m4;
        end
    end

    assign o_link.vld  = r_b_vld & ~r_last;
    assign o_link.x    = r_y;
    assign o_stat.done = r_c_vld & r_last;
    assign o_stat.sat  = r_c_vld & (r_sat_y | w_sat0 | w_sat1);
    assign o_stat.y    = r_y;

endmodule
